// ----- sv/gdp_pkg.sv -----
// Shared types and constants for the grid disk paint store.
package gdp_pkg;

    // Operation codes carried by the input channel
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_SET   = 2'd1,
        OP_GET   = 2'd2,
        OP_PAINT = 2'd3
    } op_t;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 2'd2;
    localparam logic [30:0] CELL_SIZE_RST = 31'd65536;

    // Bounds divider: 33-bit magnitude by 31-bit cell size
    localparam int DVD_W = 33;
    localparam int DSR_W = 31;
    localparam int DIV_CNT_W = 6;
    localparam int QW = 34;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_SET,
        ST_GET,
        ST_CLEAR,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CLIP,
        ST_CHECK,
        ST_MULX,
        ST_MULZ,
        ST_ROW0,
        ST_ROW,
        ST_ROWSQ,
        ST_CA,
        ST_CB,
        ST_CC,
        ST_NEXTROW,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic mem_we;
        logic wr_zero;
        logic sweep_init;
        logic x_step;
        logic row_next;
        logic div_start;
        logic div_store;
        logic clip;
        logic mulx;
        logic mulz;
        logic row_init;
        logic row_start;
        logic row_sq;
        logic cell_mag;
        logic cell_sq;
        logic res_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic resize;
        op_t  op;
        logic pos_valid;
        logic map_empty;
        logic size_zero;
        logic div_done;
        logic div_last;
        logic box_empty;
        logic x_end;
        logic y_end;
        logic row_ok;
        logic cell_ok;
        logic cell_in;
        logic out_free;
    } stat_t;

endpackage

// ----- sv/gdp_in_if.sv -----
// Input channel: one operation per transfer.
interface gdp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    logic [7:0]  material;
    logic [31:0] center_x;
    logic [31:0] center_z;
    logic [30:0] radius;

    modport source (output valid, opcode, cell_x, cell_y, material, center_x, center_z,
                    radius, input ready);
    modport sink (input valid, opcode, cell_x, cell_y, material, center_x, center_z,
                  radius, output ready);
endinterface

// ----- sv/gdp_out_if.sv -----
// Result channel: one result per operation.
interface gdp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_material;
    logic       position_valid;

    modport source (output valid, read_material, position_valid, input ready);
    modport sink (input valid, read_material, position_valid, output ready);
endinterface

// ----- sv/gdp_cfg_if.sv -----
// Configuration write channel.
interface gdp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/gdp_div.sv -----
// Restoring divider, one quotient bit per cycle, for the paint bounding box.
module gdp_div
    import gdp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0]     dvd_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DSR_W:0]       rem_sh;
    logic [DSR_W:0]       rem_next;
    logic                 q_bit;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        q_bit  = rem_sh >= {1'b0, divisor};
        rem_next = q_bit ? rem_sh - {1'b0, divisor} : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DVD_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Quotient bits shift in as the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
            rem_reg <= rem_next[DSR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- sv/gdp_dp.sv -----
// Datapath: configuration, item registers, cell memory, sweep counters, disk test.
module gdp_dp
    import gdp_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_fire,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            opcode,
    input  logic [15:0]           cell_x,
    input  logic [15:0]           cell_y,
    input  logic [7:0]            material,
    input  logic [31:0]           center_x,
    input  logic [31:0]           center_z,
    input  logic [30:0]           radius,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [7:0]            read_material,
    output logic                  position_valid
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = XW + 1;
    localparam int HW    = YW + 1;
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int MW    = ((XW > YW) ? XW : YW) + 1;
    localparam int PW    = MW + 31;
    localparam int EW    = PW + 2;
    localparam int BW    = QW + 1;

    // Configuration
    logic [8:0]  map_width_reg;
    logic [8:0]  map_height_reg;
    logic [30:0] cell_size_reg;

    // Item
    op_t         op_reg;
    logic [15:0] cell_x_reg;
    logic [15:0] cell_y_reg;
    logic [7:0]  material_reg;
    logic [31:0] cx_reg;
    logic [31:0] cz_reg;
    logic [30:0] radius_reg;

    // Sweep
    logic [XW-1:0] x_reg, x_lo_reg, x_hi_reg;
    logic [YW-1:0] y_reg, y_lo_reg, y_hi_reg;
    logic          box_empty_reg;

    // Bounds division
    logic [1:0]          div_idx_reg;
    logic                div_neg_reg;
    logic signed [QW-1:0] q_reg [4];
    logic                div_done;
    logic [DVD_W-1:0]    div_q;
    logic [DVD_W-1:0]    div_dvd;
    logic signed [QW-1:0] num;
    logic [31:0]         c_sel;

    // Disk test
    logic [PW-1:0]        prod_reg;
    logic signed [EW-1:0] ex0_reg, ex_reg, ez_reg;
    logic [31:0]          dz_reg, dx_reg;
    logic                 row_ok_reg, cell_ok_reg;
    logic [63:0]          bz_reg, ax_reg, r2_reg;

    // Memory
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] item_addr;
    logic [7:0]    wr_data;

    // Result
    logic       out_valid_reg;
    logic [7:0] read_material_reg;
    logic       position_valid_reg;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          pos_valid;
    logic [31:0]   lim;
    logic [MW-1:0] mul_a;
    logic [PW-1:0] mul_p;
    logic signed [EW-1:0] two_cx, two_cz, two_s;
    logic [EW-1:0] ez_mag, ex_mag;
    logic signed [BW-1:0] wm1, hm1, lo_x, hi_x, lo_y, hi_y;
    logic signed [BW-1:0] q0, q1, q2, q3;

    // Effective map size saturates to the store dimensions
    assign eff_w = (32'(map_width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(map_width_reg);
    assign eff_h = (32'(map_height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                                                      : HW'(map_height_reg);

    assign pos_valid = !cell_x_reg[15] && !cell_y_reg[15]
                    && ({1'b0, cell_x_reg[14:0]} < 16'(eff_w))
                    && ({1'b0, cell_y_reg[14:0]} < 16'(eff_h));
    assign item_addr = {cell_y_reg[YW-1:0], cell_x_reg[XW-1:0]};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= '0;
            map_height_reg <= '0;
            cell_size_reg  <= CELL_SIZE_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data[8:0];
                REG_MAP_HEIGHT: map_height_reg <= cfg_data[8:0];
                REG_CELL_SIZE:  cell_size_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg       <= op_t'(opcode);
            cell_x_reg   <= cell_x;
            cell_y_reg   <= cell_y;
            material_reg <= material;
            cx_reg       <= center_x;
            cz_reg       <= center_z;
            radius_reg   <= radius;
        end
    end

    // Divider numerator: order is cx-r, cx+r, cz-r, cz+r
    assign c_sel = div_idx_reg[1] ? cz_reg : cx_reg;
    assign num   = div_idx_reg[0] ? QW'($signed(c_sel)) + $signed({3'b0, radius_reg})
                                  : QW'($signed(c_sel)) - $signed({3'b0, radius_reg});
    assign div_dvd = num[QW-1] ? ~num[DVD_W-1:0] : num[DVD_W-1:0];

    gdp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (cell_size_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_idx_reg <= '0;
        else if (cmd.load_item)
            div_idx_reg <= '0;
        else if (cmd.div_store)
            div_idx_reg <= div_idx_reg + 1'b1;
    end

    // Floor of a negative numerator n is the complement of (~n)/s
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            div_neg_reg <= num[QW-1];
        if (cmd.div_store)
            q_reg[div_idx_reg] <= div_neg_reg ? $signed(~{1'b0, div_q})
                                              : $signed({1'b0, div_q});
    end

    // Clip the box to the map
    assign q0  = BW'(q_reg[0]);
    assign q1  = BW'(q_reg[1]);
    assign q2  = BW'(q_reg[2]);
    assign q3  = BW'(q_reg[3]);
    assign wm1 = $signed(BW'(eff_w)) - BW'(1);
    assign hm1 = $signed(BW'(eff_h)) - BW'(1);
    assign lo_x = q0[BW-1] ? '0 : q0;
    assign hi_x = (q1 > wm1) ? wm1 : q1;
    assign lo_y = q2[BW-1] ? '0 : q2;
    assign hi_y = (q3 > hm1) ? hm1 : q3;

    // Sweep counters and bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            x_lo_reg      <= '0;
            x_hi_reg      <= '1;
            y_lo_reg      <= '0;
            y_hi_reg      <= '1;
            box_empty_reg <= 1'b0;
        end
        else if (cmd.sweep_init)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            x_lo_reg <= '0;
            x_hi_reg <= '1;
            y_hi_reg <= '1;
        end
        else if (cmd.load_item)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            x_lo_reg <= '0;
            x_hi_reg <= XW'(eff_w - WW'(1));
            y_hi_reg <= YW'(eff_h - HW'(1));
        end
        else if (cmd.clip)
        begin
            x_lo_reg      <= lo_x[XW-1:0];
            x_hi_reg      <= hi_x[XW-1:0];
            y_lo_reg      <= lo_y[YW-1:0];
            y_hi_reg      <= hi_y[YW-1:0];
            box_empty_reg <= (hi_x < lo_x) || (hi_y < lo_y);
        end
        else if (cmd.row_init)
        begin
            y_reg <= y_lo_reg;
        end
        else if (cmd.row_start)
        begin
            x_reg <= x_lo_reg;
        end
        else if (cmd.row_next)
        begin
            x_reg <= x_lo_reg;
            y_reg <= y_reg + 1'b1;
        end
        else if (cmd.x_step)
        begin
            x_reg <= x_reg + 1'b1;
        end
    end

    // Cell centre offsets, doubled: (2i+1)*s - 2c, stepped by 2s
    assign lim    = {radius_reg, 1'b0};
    assign mul_a  = cmd.mulz ? MW'({y_lo_reg, 1'b1}) : MW'({x_lo_reg, 1'b1});
    assign mul_p  = PW'(mul_a) * PW'(cell_size_reg);
    assign two_cx = $signed({{(EW-33){cx_reg[31]}}, cx_reg, 1'b0});
    assign two_cz = $signed({{(EW-33){cz_reg[31]}}, cz_reg, 1'b0});
    assign two_s  = $signed({{(EW-32){1'b0}}, cell_size_reg, 1'b0});
    assign ez_mag = ez_reg[EW-1] ? EW'(-ez_reg) : EW'(ez_reg);
    assign ex_mag = ex_reg[EW-1] ? EW'(-ex_reg) : EW'(ex_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.clip)
            r2_reg <= {32'b0, lim} * {32'b0, lim};
        if (cmd.mulx || cmd.mulz)
            prod_reg <= mul_p;
        if (cmd.mulz)
            ex0_reg <= $signed({2'b00, prod_reg}) - two_cx;
        if (cmd.row_init)
            ez_reg <= $signed({2'b00, prod_reg}) - two_cz;
        else if (cmd.row_next)
            ez_reg <= ez_reg + two_s;
        if (cmd.row_start)
        begin
            ex_reg     <= ex0_reg;
            dz_reg     <= ez_mag[31:0];
            row_ok_reg <= ez_mag <= EW'(lim);
        end
        else if (cmd.x_step)
        begin
            ex_reg <= ex_reg + two_s;
        end
        if (cmd.row_sq)
            bz_reg <= {32'b0, dz_reg} * {32'b0, dz_reg};
        if (cmd.cell_mag)
        begin
            dx_reg      <= ex_mag[31:0];
            cell_ok_reg <= ex_mag <= EW'(lim);
        end
        if (cmd.cell_sq)
            ax_reg <= {32'b0, dx_reg} * {32'b0, dx_reg};
    end

    // Cell memory
    assign wr_addr = (op_reg == OP_SET && !cmd.wr_zero) ? item_addr : {y_reg, x_reg};
    assign wr_data = cmd.wr_zero ? 8'd0 : material_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[item_addr];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            read_material_reg  <= (op_reg == OP_GET && pos_valid) ? rd_data_reg : 8'd0;
            position_valid_reg <= (op_reg == OP_SET || op_reg == OP_GET) && pos_valid;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_material  = read_material_reg;
    assign position_valid = position_valid_reg;

    // Status
    always_comb
    begin
        stat.resize    = cfg_fire && (cfg_index == REG_MAP_WIDTH
                                   || cfg_index == REG_MAP_HEIGHT);
        stat.op        = op_reg;
        stat.pos_valid = pos_valid;
        stat.map_empty = (eff_w == '0) || (eff_h == '0);
        stat.size_zero = cell_size_reg == '0;
        stat.div_done  = div_done;
        stat.div_last  = div_idx_reg == 2'd3;
        stat.box_empty = box_empty_reg;
        stat.x_end     = x_reg == x_hi_reg;
        stat.y_end     = y_reg == y_hi_reg;
        stat.row_ok    = row_ok_reg;
        stat.cell_ok   = cell_ok_reg;
        stat.cell_in   = ({1'b0, ax_reg} + {1'b0, bz_reg}) <= {1'b0, r2_reg};
        stat.out_free  = !out_valid_reg || out_ready;
    end

endmodule

// ----- sv/gdp_ctrl.sv -----
// Controller: sequences clear sweeps, set/get, bounds division and the paint walk.
module gdp_ctrl
    import gdp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.mem_we  = 1'b1;
                cmd.wr_zero = 1'b1;
                if (stat.x_end && stat.y_end)
                    state_next = ST_IDLE;
                else if (stat.x_end)
                    cmd.row_next = 1'b1;
                else
                    cmd.x_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.op)
                    OP_CLEAR: state_next = stat.map_empty ? ST_DONE : ST_CLEAR;
                    OP_SET:   state_next = ST_SET;
                    OP_GET:   state_next = ST_GET;
                    OP_PAINT: state_next = stat.size_zero ? ST_DONE : ST_DIV_START;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_SET:
            begin
                cmd.mem_we = stat.pos_valid;
                state_next = ST_DONE;
            end
            ST_GET:
            begin
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                cmd.mem_we = 1'b1;
                if (stat.x_end && stat.y_end)
                    state_next = ST_DONE;
                else if (stat.x_end)
                    cmd.row_next = 1'b1;
                else
                    cmd.x_step = 1'b1;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = stat.div_last ? ST_CLIP : ST_DIV_START;
                end
            end
            ST_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = stat.box_empty ? ST_DONE : ST_MULX;
            end
            ST_MULX:
            begin
                cmd.mulx   = 1'b1;
                state_next = ST_MULZ;
            end
            ST_MULZ:
            begin
                cmd.mulz   = 1'b1;
                state_next = ST_ROW0;
            end
            ST_ROW0:
            begin
                cmd.row_init = 1'b1;
                state_next   = ST_ROW;
            end
            ST_ROW:
            begin
                cmd.row_start = 1'b1;
                state_next    = ST_ROWSQ;
            end
            ST_ROWSQ:
            begin
                cmd.row_sq = 1'b1;
                state_next = stat.row_ok ? ST_CA : ST_NEXTROW;
            end
            ST_CA:
            begin
                cmd.cell_mag = 1'b1;
                state_next   = ST_CB;
            end
            ST_CB:
            begin
                cmd.cell_sq = 1'b1;
                state_next  = ST_CC;
            end
            ST_CC:
            begin
                cmd.mem_we = stat.cell_ok && stat.cell_in;
                if (stat.x_end)
                    state_next = ST_NEXTROW;
                else
                begin
                    cmd.x_step = 1'b1;
                    state_next = ST_CA;
                end
            end
            ST_NEXTROW:
            begin
                if (stat.y_end)
                    state_next = ST_DONE;
                else
                begin
                    cmd.row_next = 1'b1;
                    state_next   = ST_ROW;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A map resize wipes the store
        if (stat.resize)
        begin
            cmd.x_step     = 1'b0;
            cmd.row_next   = 1'b0;
            cmd.load_item  = 1'b0;
            cmd.mem_we     = 1'b0;
            cmd.sweep_init = 1'b1;
            in_ready       = 1'b0;
            state_next     = ST_INIT;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("item accepted but controller stayed idle");

    a_no_accept_in_wipe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> !in_ready)
        else $error("input ready during store wipe");

    a_result_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> stat.out_free)
        else $error("result loaded over a pending result");

    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && stat.out_free)
            |=> (state_reg == ST_IDLE || state_reg == ST_INIT))
        else $error("controller did not return after result");

endmodule

// ----- sv/grid_disk_paint_store_core.sv -----
// Top level of the grid disk paint store: controller, datapath and channels.
// Set and get write or read one cell; clear sweeps the whole map; paint runs
// four bounds divisions, then walks each box row and, for rows the disk reaches,
// each cell of the row.
// One operation at a time; the result register frees the input side early.
// Reset and map_width/map_height writes wipe all 2^(XW+YW) cells of the store
// (65536 at the default size), during which no operation is taken.
module grid_disk_paint_store_core
    import gdp_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    gdp_in_if.sink    in_ch,
    gdp_out_if.source out_ch,
    gdp_cfg_if.sink   cfg_ch
);

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign in_ch.ready  = in_ready;
    assign cfg_ch.ready = 1'b1;

    gdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gdp_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_fire       (cfg_ch.valid),
        .cfg_index      (cfg_ch.index),
        .cfg_data       (cfg_ch.data),
        .opcode         (in_ch.opcode),
        .cell_x         (in_ch.cell_x),
        .cell_y         (in_ch.cell_y),
        .material       (in_ch.material),
        .center_x       (in_ch.center_x),
        .center_z       (in_ch.center_z),
        .radius         (in_ch.radius),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .read_material  (out_ch.read_material),
        .position_valid (out_ch.position_valid)
    );

endmodule
